// ===== hdl/pvsl_pkg.sv =====
package pvsl_pkg;

  localparam int unsigned VelFracBits  = 16;
  localparam int unsigned TimeFracBits = 24;

  localparam logic [63:0] SnapSq =
    64'((65'd1 << (2 * VelFracBits)) / 65'd100000000);

  localparam logic [30:0] AccelReset = 31'd65536;
  localparam logic [30:0] SpeedReset = 31'd65536;
  localparam logic [23:0] TickReset  = 24'd16777;

  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_LIM,
    OP_MD,
    OP_MDSQ,
    OP_SQA,
    OP_SQB,
    OP_CMP,
    OP_ROOT,
    OP_MULA,
    OP_DIV,
    OP_MULB,
    OP_SETB,
    OP_FIN,
    OP_DLOAD,
    OP_HLOAD,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    PH_GOAL,
    PH_DELTA,
    PH_HELD
  } phase_e;

  typedef struct packed {
    op_e    op;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic gt;
    logic snap;
    logic snap_held;
    logic last;
    logic tick_zero;
  } stat_t;

endpackage

// ===== hdl/planar_velocity_slew_limiter.sv =====
// Each accepted word is a goal velocity; the block clamps it to the speed limit, moves the held
// velocity towards it by at most the acceleration limit times the tick period, or sets it to the
// goal when they lie within the snap distance, clamps that to the speed limit and returns both.
// One word is worked on at a time. Each of up to three magnitude clamps runs a bit-serial square
// root and two bit-serial divisions. A new word is taken as soon as the previous result has moved
// to the output register.
module planar_velocity_slew_limiter import pvsl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // goal_x [31:0], goal_y [63:32]
  input  logic [63:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // limited_goal_x [31:0], limited_goal_y [63:32], out_vel_x [95:64], out_vel_y [127:96]
  output logic [127:0] m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t st;

  pvsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  pvsl_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .st_o      (st),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (s_axis_tdata_i),
    .out_data_o(m_axis_tdata_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again straight after an accepted word");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_OUT |=> m_axis_tvalid_o)
    else $error("result register loaded without valid");

endmodule

// ===== hdl/pvsl_ctrl.sv =====
module pvsl_ctrl import pvsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output cmd_t  cmd_o,
  input  stat_t st_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LIM   = 5'd1;
  localparam logic [4:0] S_MD    = 5'd2;
  localparam logic [4:0] S_MDSQ  = 5'd3;
  localparam logic [4:0] S_SQA   = 5'd4;
  localparam logic [4:0] S_SQB   = 5'd5;
  localparam logic [4:0] S_CMP   = 5'd6;
  localparam logic [4:0] S_ROOT  = 5'd7;
  localparam logic [4:0] S_MULA  = 5'd8;
  localparam logic [4:0] S_DIVA  = 5'd9;
  localparam logic [4:0] S_MULB  = 5'd10;
  localparam logic [4:0] S_DIVB  = 5'd11;
  localparam logic [4:0] S_SETB  = 5'd12;
  localparam logic [4:0] S_FIN   = 5'd13;
  localparam logic [4:0] S_DLOAD = 5'd14;
  localparam logic [4:0] S_HLOAD = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  logic [4:0] state_q, state_d;
  phase_e     phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.phase = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          phase_d  = PH_GOAL;
          state_d  = S_LIM;
        end
      end
      S_LIM: begin
        cmd_o.op = OP_LIM;
        state_d  = S_MD;
      end
      S_MD: begin
        cmd_o.op = OP_MD;
        state_d  = S_MDSQ;
      end
      S_MDSQ: begin
        cmd_o.op = OP_MDSQ;
        state_d  = S_SQA;
      end
      S_SQA: begin
        cmd_o.op = OP_SQA;
        state_d  = S_SQB;
      end
      S_SQB: begin
        cmd_o.op = OP_SQB;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        if (phase_q == PH_DELTA && st_i.snap) begin
          state_d = S_FIN;
        end else if (st_i.gt) begin
          state_d = S_ROOT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        if (st_i.last) begin
          state_d = S_MULA;
        end
      end
      S_MULA: begin
        cmd_o.op = OP_MULA;
        state_d  = S_DIVA;
      end
      S_DIVA: begin
        cmd_o.op = OP_DIV;
        if (st_i.last) begin
          state_d = S_MULB;
        end
      end
      S_MULB: begin
        cmd_o.op = OP_MULB;
        state_d  = S_DIVB;
      end
      S_DIVB: begin
        cmd_o.op = OP_DIV;
        if (st_i.last) begin
          state_d = S_SETB;
        end
      end
      S_SETB: begin
        cmd_o.op = OP_SETB;
        state_d  = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        case (phase_q)
          PH_GOAL:  state_d = st_i.tick_zero ? S_DONE : S_DLOAD;
          PH_DELTA: state_d = st_i.snap_held ? S_DONE : S_HLOAD;
          default:  state_d = S_DONE;
        endcase
      end
      S_DLOAD: begin
        cmd_o.op = OP_DLOAD;
        phase_d  = PH_DELTA;
        state_d  = S_SQA;
      end
      S_HLOAD: begin
        cmd_o.op = OP_HLOAD;
        phase_d  = PH_HELD;
        state_d  = S_SQA;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_GOAL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/pvsl_dpath.sv =====
module pvsl_dpath import pvsl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output stat_t        st_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i,
  input  logic [63:0]  in_data_i,
  output logic [127:0] out_data_o
);

  logic        [30:0]  accel_q, speed_q;
  logic        [23:0]  tick_q;
  logic signed [31:0]  gx_q, gy_q, hx_q, hy_q;
  logic signed [32:0]  va_q, vb_q;
  logic        [63:0]  lim_sq_q, mdsq_q, prod_q, acc_q, rad_q;
  logic        [30:0]  md_q;
  logic                gt_q, snap_q;
  logic        [33:0]  rem_q;
  logic        [31:0]  root_q, drem_q, dq_q;
  logic        [4:0]   cnt_q;
  logic        [127:0] out_q;

  logic        [32:0]  abs_a, abs_b;
  logic        [31:0]  mag_a, mag_b, mul_a, mul_b;
  logic        [63:0]  mul_p;
  logic        [30:0]  num;
  logic        [64:0]  sum65;
  logic        [63:0]  sum, thr;
  logic        [35:0]  rem_sh, trial;
  logic                root_ge;
  logic        [32:0]  dsh, dsub;
  logic                div_ge;
  logic signed [32:0]  qpos, qs_a, qs_b;

  assign abs_a = va_q[32] ? 33'(-va_q) : 33'(va_q);
  assign abs_b = vb_q[32] ? 33'(-vb_q) : 33'(vb_q);
  assign mag_a = abs_a[31:0];
  assign mag_b = abs_b[31:0];
  assign num   = (cmd_i.phase == PH_DELTA) ? md_q : speed_q;
  assign thr   = (cmd_i.phase == PH_DELTA) ? mdsq_q : lim_sq_q;

  always_comb begin
    case (cmd_i.op)
      OP_LIM: begin
        mul_a = {1'b0, speed_q};
        mul_b = {1'b0, speed_q};
      end
      OP_MD: begin
        mul_a = {1'b0, accel_q};
        mul_b = {8'd0, tick_q};
      end
      OP_MDSQ: begin
        mul_a = {1'b0, md_q};
        mul_b = {1'b0, md_q};
      end
      OP_SQA: begin
        mul_a = mag_a;
        mul_b = mag_a;
      end
      OP_SQB: begin
        mul_a = mag_b;
        mul_b = mag_b;
      end
      OP_MULA: begin
        mul_a = mag_a;
        mul_b = {1'b0, num};
      end
      OP_MULB: begin
        mul_a = mag_b;
        mul_b = {1'b0, num};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sum65 = {1'b0, acc_q} + {1'b0, prod_q};
  assign sum   = sum65[64] ? {64{1'b1}} : sum65[63:0];

  assign rem_sh  = {rem_q, rad_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign root_ge = (rem_sh >= trial);

  assign dsh    = {drem_q, dq_q[31]};
  assign dsub   = dsh - {1'b0, root_q};
  assign div_ge = (dsh >= {1'b0, root_q});

  assign qpos = signed'({1'b0, dq_q});
  assign qs_a = va_q[32] ? -qpos : qpos;
  assign qs_b = vb_q[32] ? -qpos : qpos;

  assign st_o.gt        = (sum > thr);
  assign st_o.snap      = (sum <= SnapSq);
  assign st_o.snap_held = snap_q;
  assign st_o.last      = (cnt_q == 5'd31);
  assign st_o.tick_zero = (tick_q == 24'd0);

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= AccelReset;
      speed_q <= SpeedReset;
      tick_q  <= TickReset;
      hx_q    <= '0;
      hy_q    <= '0;
      gt_q    <= 1'b0;
      snap_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACCEL_LIMIT: accel_q <= cfg_data_i;
          REG_SPEED_LIMIT: speed_q <= cfg_data_i;
          REG_TICK_PERIOD: tick_q  <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_CMP: begin
          gt_q   <= st_o.gt;
          snap_q <= st_o.snap;
          cnt_q  <= '0;
        end
        OP_ROOT, OP_DIV: cnt_q <= cnt_q + 5'd1;
        OP_MULA, OP_MULB: cnt_q <= '0;
        OP_FIN: begin
          case (cmd_i.phase)
            PH_DELTA: begin
              if (snap_q || !gt_q) begin
                hx_q <= gx_q;
                hy_q <= gy_q;
              end else begin
                hx_q <= 32'(hx_q + signed'(va_q[31:0]));
                hy_q <= 32'(hy_q + signed'(vb_q[31:0]));
              end
            end
            PH_HELD: begin
              if (gt_q) begin
                hx_q <= va_q[31:0];
                hy_q <= vb_q[31:0];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        va_q <= 33'(signed'(in_data_i[31:0]));
        vb_q <= 33'(signed'(in_data_i[63:32]));
      end
      OP_LIM:  lim_sq_q <= mul_p;
      OP_MD:   md_q <= mul_p[TimeFracBits +: 31];
      OP_MDSQ: mdsq_q <= mul_p;
      OP_SQA:  prod_q <= mul_p;
      OP_SQB: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      OP_CMP: begin
        acc_q  <= sum;
        rad_q  <= sum;
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_ROOT: begin
        rad_q  <= {rad_q[61:0], 2'b00};
        rem_q  <= root_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_q <= {root_q[30:0], root_ge};
      end
      OP_MULA: begin
        drem_q <= mul_p[63:32];
        dq_q   <= mul_p[31:0];
      end
      OP_DIV: begin
        drem_q <= div_ge ? dsub[31:0] : dsh[31:0];
        dq_q   <= {dq_q[30:0], div_ge};
      end
      OP_MULB: begin
        va_q   <= qs_a;
        drem_q <= mul_p[63:32];
        dq_q   <= mul_p[31:0];
      end
      OP_SETB: vb_q <= qs_b;
      OP_FIN: begin
        if (cmd_i.phase == PH_GOAL) begin
          gx_q <= va_q[31:0];
          gy_q <= vb_q[31:0];
        end
      end
      OP_DLOAD: begin
        va_q <= 33'(gx_q) - 33'(hx_q);
        vb_q <= 33'(gy_q) - 33'(hy_q);
      end
      OP_HLOAD: begin
        va_q <= 33'(hx_q);
        vb_q <= 33'(hy_q);
      end
      OP_OUT: out_q <= {hy_q, hx_q, gy_q, gx_q};
      default: ;
    endcase
  end

endmodule

// ===== dv/pvsl_checker.sv =====
module pvsl_checker import pvsl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [63:0]  s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [127:0] m_axis_tdata_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o,
  output int unsigned  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] goal_y;
    logic [31:0] goal_x;
  } plan_t;

  plan_t       planned_q[$];
  logic [30:0] accel_lim;
  logic [30:0] speed_lim;
  logic [23:0] tick;
  logic signed [63:0] held_x, held_y;

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] sum_sq(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0] ma, mb, sa, sb;
    ma = abs64(a);
    mb = abs64(b);
    if (ma > 64'hFFFF_FFFF || mb > 64'hFFFF_FFFF) return '1;
    sa = ma * mb * 0 + ma * ma;
    sb = mb * mb;
    if (sa > ~sb) return '1;
    return sa + sb;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] scaled(logic signed [63:0] v, logic [63:0] num,
                                                logic [63:0] den);
    logic [63:0] m, q;
    if (den == 0) return 0;
    m = abs64(v);
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    if (num > 64'h7FFF_FFFF) num = 64'h7FFF_FFFF;
    q = m * num / den;
    return v < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic plan_t plan_tick(logic [63:0] word);
    logic signed [63:0] gx, gy, dx, dy;
    logic [63:0] lim_sq, s2, d2, md;
    plan_t p;
    gx = $signed(word[31:0]);
    gy = $signed(word[63:32]);
    lim_sq = 64'(speed_lim) * 64'(speed_lim);
    s2 = sum_sq(gx, gy);
    if (s2 > lim_sq) begin
      gx = scaled(gx, 64'(speed_lim), root64(s2));
      gy = scaled(gy, 64'(speed_lim), root64(s2));
    end
    if (tick != 0) begin
      dx = gx - held_x;
      dy = gy - held_y;
      d2 = sum_sq(dx, dy);
      md = (64'(accel_lim) * 64'(tick)) >> TimeFracBits;
      if (d2 <= SnapSq) begin
        held_x = gx;
        held_y = gy;
      end else begin
        if (d2 > md * md) begin
          held_x += scaled(dx, md, root64(d2));
          held_y += scaled(dy, md, root64(d2));
        end else begin
          held_x = gx;
          held_y = gy;
        end
        s2 = sum_sq(held_x, held_y);
        if (s2 > lim_sq) begin
          held_x = scaled(held_x, 64'(speed_lim), root64(s2));
          held_y = scaled(held_y, 64'(speed_lim), root64(s2));
        end
        held_x = $signed(held_x[31:0]);
        held_y = $signed(held_y[31:0]);
      end
    end
    p.goal_x = gx[31:0];
    p.goal_y = gy[31:0];
    p.vel_x  = held_x[31:0];
    p.vel_y  = held_y[31:0];
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = planned_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    plan_t got, want;
    if (!rst_ni) begin
      accel_lim = AccelReset;
      speed_lim = SpeedReset;
      tick      = TickReset;
      held_x    = 0;
      held_y    = 0;
      planned_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACCEL_LIMIT: accel_lim = cfg_data_i;
          REG_SPEED_LIMIT: speed_lim = cfg_data_i;
          REG_TICK_PERIOD: tick      = cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) planned_q.push_back(plan_tick(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        checked_o++;
        if (planned_q.size() == 0) begin
          $display("unexpected word at %0t: %h", $time, m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = planned_q.pop_front();
          if (got.goal_x !== want.goal_x) report("limited_goal_x", got.goal_x, want.goal_x);
          if (got.goal_y !== want.goal_y) report("limited_goal_y", got.goal_y, want.goal_y);
          if (got.vel_x !== want.vel_x) report("out_vel_x", got.vel_x, want.vel_x);
          if (got.vel_y !== want.vel_y) report("out_vel_y", got.vel_y, want.vel_y);
        end
      end
    end
  end
endmodule

// ===== dv/tb_planar_velocity_slew_limiter.sv =====
module tb_planar_velocity_slew_limiter import pvsl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_valid = 0;
  logic         s_ready;
  logic [63:0]  s_data = '0;
  logic         m_valid;
  logic         m_ready = 0;
  logic [127:0] m_data;
  logic         cfg_we = 0;
  logic [1:0]   cfg_idx = REG_ACCEL_LIMIT;
  logic [30:0]  cfg_data = '0;
  int unsigned  fail_count, pending, checked;
  int unsigned  sent = 0;
  bit           stall_free = 0;

  always #5 clk_i = ~clk_i;

  planar_velocity_slew_limiter i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  pvsl_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_i(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  function automatic int unsigned gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) m_ready <= (gap_len() == 0);
  end

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 262144)) - 131072);
      3: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 8388608)) - 4194304);
    endcase
  endfunction

  task automatic send_word(logic [31:0] gx, logic [31:0] gy);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      s_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1;
    s_data  <= {gy, gx};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    s_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [30:0] acc, logic [30:0] spd, logic [23:0] tk);
    drain();
    write_reg(REG_ACCEL_LIMIT, acc);
    write_reg(REG_SPEED_LIMIT, spd);
    write_reg(REG_TICK_PERIOD, 31'(tk));
    write_reg(REG_UNUSED, 31'($urandom));
    cfg_we <= 0;
  endtask

  initial begin
    #25ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 32'h8000_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h0000_8000, 32'hFFFF_8000);
    send_word(32'h0000_0003, 32'h0000_0002);
    send_word(32'h0000_0004, 32'h0000_0003);
    set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h8000_0000);
    set_all(31'd200000, 31'd0, 24'd0);
    send_word(32'h0001_0000, 32'h0002_0000);
    send_word(32'hFFFF_0000, 32'h0000_0000);
    set_all(31'd0, 31'd98304, 24'd100000);
    send_word(32'h0005_0000, 32'h0000_0000);
    set_all(31'd1, 31'd65536, 24'd1);
    send_word(32'h0000_0001, 32'h0000_0001);
    send_word(32'h0002_0000, 32'hFFFE_0000);
    // The sender holds off once until every result is back.
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      stall_free = (ph == 3);
      case (ph)
        0: set_all(AccelReset, SpeedReset, TickReset);
        1: set_all(31'($urandom), 31'($urandom), 24'($urandom_range(0, 24'hFF_FFFF)));
        2: set_all(31'($urandom_range(0, 31'h7FFF_FFFF)), 31'($urandom_range(1000, 500000)),
                   24'd0);
        3: set_all(31'($urandom_range(0, 4000000)), 31'($urandom_range(0, 31'h7FFF_FFFF)),
                   24'($urandom_range(1, 1000000)));
        4: set_all(31'd0, 31'h7FFF_FFFF, 24'hFF_FFFF);
        default: set_all(31'($urandom_range(100000, 900000)), 31'($urandom_range(1, 300000)),
                         24'($urandom_range(1000, 70000)));
      endcase
      repeat (190) send_word(rand_vel(), rand_vel());
    end
    stall_free = 0;
    drain();
    $display("Sent %0d goal words over eleven register settings, %0d result words checked.",
             sent, checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
